// File: rtl/core/ttbg_pkg.sv
// Shared types and constants of the two-tone beep generator.
// No dependencies; every rtl/core file refers to it by scoped names.
`default_nettype none

package ttbg_pkg;

  // Field widths
  localparam int unsigned PeriodW  = 14;
  localparam int unsigned LenW     = 12;
  localparam int unsigned AmpW     = 15;
  localparam int unsigned FadeW    = 11;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ProdW    = AmpW + FadeW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  // Register indexes of the write port
  localparam logic [CfgIdxW-1:0] REG_TONE_A_PERIOD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TONE_B_PERIOD = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TONE_LENGTH   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAP_LENGTH    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_AMPLITUDE     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FADE_LENGTH   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MUTED         = 3'd6;

  // Beep segments
  localparam logic [1:0] SEG_IDLE   = 2'd0;
  localparam logic [1:0] SEG_TONE_A = 2'd1;
  localparam logic [1:0] SEG_GAP    = 2'd2;
  localparam logic [1:0] SEG_TONE_B = 2'd3;

  // Minimum square period
  localparam logic [PeriodW-1:0] MIN_PERIOD = 14'd4;

  typedef struct packed {
    logic [PeriodW-1:0] tone_a_period;
    logic [PeriodW-1:0] tone_b_period;
    logic [LenW-1:0]    tone_length;
    logic [LenW-1:0]    gap_length;
    logic [AmpW-1:0]    amplitude;
    logic [FadeW-1:0]   fade_length;
    logic               muted;
  } cfg_t;

  // Per-tick result info, before the fade division is applied
  typedef struct packed {
    logic            playing;
    logic            last;
    logic            accepted;
    logic            neg;
    logic            need_div;
    logic [AmpW-1:0] mag;
  } tick_t;

endpackage

`default_nettype wire

// File: rtl/core/ttbg_divider.sv
// Shared restoring divider for the fade gain: amplitude*n / fade, one quotient
// bit per cycle. Depends on ttbg_pkg.
`default_nettype none

module ttbg_divider (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ttbg_pkg::ProdW-1:0] dividend_i,
  input  wire logic [ttbg_pkg::FadeW-1:0] divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [ttbg_pkg::AmpW-1:0]       quotient_o
);

  localparam int unsigned AmpW  = ttbg_pkg::AmpW;
  localparam int unsigned FadeW = ttbg_pkg::FadeW;
  localparam int unsigned StepW = $clog2(AmpW);
  localparam logic [StepW-1:0] LastStep = StepW'(AmpW - 1);

  logic               busy_q, busy_d;
  logic [StepW-1:0]   cnt_q, cnt_d;
  logic [FadeW-1:0]   rem_q, rem_d;
  logic [FadeW-1:0]   div_q, div_d;
  logic [AmpW-1:0]    quo_q, quo_d;
  logic [FadeW:0]     trial;
  logic               fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  // The quotient is known to fit AmpW bits, so the top bits start as remainder.
  always_comb begin
    trial  = {rem_q, quo_q[AmpW-1]};
    fits   = trial >= {1'b0, div_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i[ttbg_pkg::ProdW-1:AmpW];
      quo_d  = dividend_i[AmpW-1:0];
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? FadeW'(trial - {1'b0, div_q}) : trial[FadeW-1:0];
      quo_d = {quo_q[AmpW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = busy_q && (cnt_q == LastStep);
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: rtl/core/ttbg_step.sv
// Beep sequencer state (segment, position, square phase) and the per-tick
// decode of sign, fade operands and flags. Depends on ttbg_pkg.
`default_nettype none

module ttbg_step #(
  parameter int unsigned MAX_SEGMENT_SAMPLES = 4095
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       advance_i,
  input  wire logic                       request_i,
  input  wire ttbg_pkg::cfg_t             cfg_i,
  output ttbg_pkg::tick_t                 tick_o,
  output logic [ttbg_pkg::ProdW-1:0]      dividend_o,
  output logic [ttbg_pkg::FadeW-1:0]      divisor_o
);

  localparam int unsigned LenW    = ttbg_pkg::LenW;
  localparam int unsigned PeriodW = ttbg_pkg::PeriodW;
  localparam int unsigned FadeW   = ttbg_pkg::FadeW;
  localparam int unsigned ProdW   = ttbg_pkg::ProdW;
  localparam logic [LenW-1:0] SegCap =
    (MAX_SEGMENT_SAMPLES >= (2 ** LenW - 1)) ? {LenW{1'b1}} : LenW'(MAX_SEGMENT_SAMPLES);

  logic [1:0]         seg_q, seg_d;
  logic [LenW-1:0]    pos_q, pos_d;
  logic [PeriodW-1:0] ph_q, ph_d;

  logic               start;
  logic [1:0]         seg0;
  logic [LenW-1:0]    pos0;
  logic [PeriodW-1:0] ph0;
  logic [LenW-1:0]    len_sat, len, gap_len, rem;
  logic [PeriodW-1:0] period_raw, period;
  logic [FadeW-1:0]   half_len, fade, n;
  logic               fade_in, fade_out;
  logic [LenW:0]      fade_end, pos_inc;
  logic [PeriodW:0]   ph_inc;
  logic [PeriodW-1:0] ph_wrap;

  // Operands of the current tick
  always_comb begin
    start   = (seg_q == ttbg_pkg::SEG_IDLE) && request_i && !cfg_i.muted;
    seg0    = start ? ttbg_pkg::SEG_TONE_A : seg_q;
    pos0    = start ? '0 : pos_q;
    ph0     = start ? '0 : ph_q;

    len_sat = (cfg_i.tone_length > SegCap) ? SegCap : cfg_i.tone_length;
    len     = (len_sat == '0) ? LenW'(1) : len_sat;
    gap_len = (cfg_i.gap_length > SegCap) ? SegCap : cfg_i.gap_length;

    period_raw = (seg0 == ttbg_pkg::SEG_TONE_A) ? cfg_i.tone_a_period : cfg_i.tone_b_period;
    period     = (period_raw < ttbg_pkg::MIN_PERIOD) ? ttbg_pkg::MIN_PERIOD : period_raw;

    // fade = min(fade_length, len/2)
    half_len = len[LenW-1:1];
    fade     = (cfg_i.fade_length > half_len) ? half_len : cfg_i.fade_length;
    fade_in  = (fade != '0) && (pos0 < {1'b0, fade});
    fade_end = {1'b0, pos0} + {2'b00, fade};
    fade_out = (fade != '0) && !fade_in && (fade_end >= {1'b0, len});
    rem      = (pos0 < len) ? LenW'(len - pos0) : '0;
    n        = fade_in ? pos0[FadeW-1:0] : rem[FadeW-1:0];

    pos_inc = {1'b0, pos0} + 1'b1;
    ph_inc  = {1'b0, ph0} + 1'b1;
    ph_wrap = (ph_inc >= {1'b0, period}) ? '0 : ph_inc[PeriodW-1:0];
  end

  assign dividend_o = ProdW'(cfg_i.amplitude) * ProdW'(n);
  assign divisor_o  = fade;

  // Flags and next state
  always_comb begin
    seg_d           = seg0;
    pos_d           = pos0;
    ph_d            = ph0;
    tick_o          = '0;
    tick_o.accepted = start;
    unique case (seg0)
      ttbg_pkg::SEG_TONE_A, ttbg_pkg::SEG_TONE_B: begin
        tick_o.playing  = 1'b1;
        tick_o.need_div = fade_in || fade_out;
        tick_o.neg      = ph0 >= {1'b0, period[PeriodW-1:1]};
        tick_o.mag      = cfg_i.amplitude;
        if (pos_inc >= {1'b0, len}) begin
          pos_d = '0;
          ph_d  = '0;
          if (seg0 == ttbg_pkg::SEG_TONE_B) begin
            seg_d       = ttbg_pkg::SEG_IDLE;
            tick_o.last = 1'b1;
          end else begin
            seg_d = (gap_len != '0) ? ttbg_pkg::SEG_GAP : ttbg_pkg::SEG_TONE_B;
          end
        end else begin
          pos_d = pos_inc[LenW-1:0];
          ph_d  = ph_wrap;
        end
      end
      ttbg_pkg::SEG_GAP: begin
        tick_o.playing = 1'b1;
        if (pos_inc >= {1'b0, gap_len}) begin
          seg_d = ttbg_pkg::SEG_TONE_B;
          pos_d = '0;
          ph_d  = '0;
        end else begin
          pos_d = pos_inc[LenW-1:0];
        end
      end
      default: begin
        seg_d = ttbg_pkg::SEG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= ttbg_pkg::SEG_IDLE;
      pos_q <= '0;
      ph_q  <= '0;
    end else if (advance_i) begin
      seg_q <= seg_d;
      pos_q <= pos_d;
      ph_q  <= ph_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/two_tone_beep_generator_top.sv
// Two-tone beep generator, top level: config registers, tick sequencer,
// output register. Depends on ttbg_pkg, ttbg_step and ttbg_divider.
//
// Usage: each request on the s_axis side is one audio sample tick; bit 0 of
// s_axis_tdata asks for a beep. Every request yields exactly one result on
// the m_axis side: the signed sample in m_axis_tdata, the beep's final
// sample flagged by m_axis_tlast, and playing/accepted flags in m_axis_tuser.
// A beep is tone A, a silent gap, then tone B, each tone faded in and out.
// Registers are set through the cfg write port while no tick is in flight.
//
// Timing: a tick waits with its flags in the pending register; outside any
// fade ramp it then goes to the output register, inside one it first waits
// for the shared fade divider, which resolves one quotient bit per cycle.
// s_axis_tready is high only while no tick is in progress, so a new request
// is taken only once the last tick has been loaded into the output register.
// A finished result waits in the output register while the next request is
// taken; if the sink stalls, the next result waits until the register frees.
// Reset loads the register defaults, returns the sequencer to idle and
// empties the output register.
`default_nettype none

module two_tone_beep_generator_top #(
  parameter int unsigned MAX_SEGMENT_SAMPLES = 4095
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [ttbg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ttbg_pkg::CfgDataW-1:0] cfg_data_i,
  // Tick requests
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [0] request, [7:1] zero
  // Results
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [ttbg_pkg::SampleW-1:0]       m_axis_tdata,  // [15:0] sample
  output logic                               m_axis_tlast,  // last
  output logic [1:0]                         m_axis_tuser   // [0] playing, [1] accepted
);

  localparam int unsigned AmpW    = ttbg_pkg::AmpW;
  localparam int unsigned SampleW = ttbg_pkg::SampleW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  ttbg_pkg::cfg_t  cfg_q;
  ttbg_pkg::tick_t tick, pend_q;
  logic [1:0]      state_q, state_d;
  logic            in_fire, out_load;
  logic [ttbg_pkg::ProdW-1:0] dividend;
  logic [ttbg_pkg::FadeW-1:0] divisor;
  logic            div_busy, div_done;
  logic [AmpW-1:0] quotient, mag;
  logic [SampleW-1:0] mag_ext;
  logic            out_valid_q;
  logic [SampleW-1:0] sample_q;
  logic            last_q, playing_q, accepted_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tone_a_period <= 14'd10;
      cfg_q.tone_b_period <= 14'd7;
      cfg_q.tone_length   <= 12'd1440;
      cfg_q.gap_length    <= 12'd560;
      cfg_q.amplitude     <= 15'd4200;
      cfg_q.fade_length   <= 11'd64;
      cfg_q.muted         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttbg_pkg::REG_TONE_A_PERIOD: cfg_q.tone_a_period <= cfg_data_i[13:0];
        ttbg_pkg::REG_TONE_B_PERIOD: cfg_q.tone_b_period <= cfg_data_i[13:0];
        ttbg_pkg::REG_TONE_LENGTH:   cfg_q.tone_length   <= cfg_data_i[11:0];
        ttbg_pkg::REG_GAP_LENGTH:    cfg_q.gap_length    <= cfg_data_i[11:0];
        ttbg_pkg::REG_AMPLITUDE:     cfg_q.amplitude     <= cfg_data_i[14:0];
        ttbg_pkg::REG_FADE_LENGTH:   cfg_q.fade_length   <= cfg_data_i[10:0];
        ttbg_pkg::REG_MUTED:         cfg_q.muted         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  ttbg_step #(
    .MAX_SEGMENT_SAMPLES(MAX_SEGMENT_SAMPLES)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (in_fire),
    .request_i  (s_axis_tdata[0]),
    .cfg_i      (cfg_q),
    .tick_o     (tick),
    .dividend_o (dividend),
    .divisor_o  (divisor)
  );

  ttbg_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire && tick.need_div),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Tick sequencer
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = tick.need_div ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pending tick info, held while the divider runs and until the output load
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_q <= tick;
    end
  end

  // Signed sample from magnitude and half-period sign
  assign mag     = pend_q.need_div ? quotient : pend_q.mag;
  assign mag_ext = SampleW'(mag);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_q   <= pend_q.neg ? SampleW'(16'd0 - mag_ext) : mag_ext;
      last_q     <= pend_q.last;
      playing_q  <= pend_q.playing;
      accepted_q <= pend_q.accepted;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = sample_q;
  assign m_axis_tlast    = last_q;
  assign m_axis_tuser[0] = playing_q;
  assign m_axis_tuser[1] = accepted_q;

  // Checks
  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV))
    else $error("fade divider busy outside the divide state");

  a_no_accept_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("new request taken while a tick is in progress");

  a_last_is_playing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tlast || m_axis_tuser[1])) |-> m_axis_tuser[0])
    else $error("last or accepted flag on a non-playing sample");

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten before it was taken");

endmodule

`default_nettype wire
